/* rtl/espm_pkg.sv */
// Shared widths, register indexes, mode codes and reset values of the encoder speed meter.
`default_nettype none
package espm_pkg;

    localparam int TIME_WIDTH_DEF = 32;

    localparam int UNIT_W   = 2;
    localparam int LOCK_W   = 20;
    localparam int SCALE_W  = 41;
    localparam int SPEED_W  = 42;
    localparam int PERIOD_W = 33;
    localparam int INDEX_W  = 2;
    localparam int CFG_W    = SCALE_W;

    // width that holds the reset period of one second
    localparam int PER_RST_W = 20;

    localparam logic [INDEX_W-1:0] REG_UNIT_MODE    = 2'd0;
    localparam logic [INDEX_W-1:0] REG_LOCKOUT_US   = 2'd1;
    localparam logic [INDEX_W-1:0] REG_DEGREE_SCALE = 2'd2;
    localparam logic [INDEX_W-1:0] REG_RADIAN_SCALE = 2'd3;

    localparam logic [UNIT_W-1:0] MODE_DEGREE = 2'd0;
    localparam logic [UNIT_W-1:0] MODE_RADIAN = 2'd1;

    localparam logic [LOCK_W-1:0]    LOCKOUT_RESET = 20'd5000;
    localparam logic [SCALE_W-1:0]   DEGREE_RESET  = 41'd1179648000000;
    localparam logic [SCALE_W-1:0]   RADIAN_RESET  = 41'd428932117;
    localparam logic [PER_RST_W-1:0] PERIOD_RESET  = 20'd1000000;

    typedef logic [SCALE_W-1:0] scale_t;

endpackage
`default_nettype wire

/* rtl/espm_if.sv */
// Channel interfaces: edge input, speed result and configuration write.
`default_nettype none
interface espm_edge_if #(
    parameter int TIME_WIDTH = espm_pkg::TIME_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic [TIME_WIDTH-1:0] edge_time_us;
    logic                  direction_level;

    modport source (output valid, edge_time_us, direction_level, input ready);
    modport sink   (input valid, edge_time_us, direction_level, output ready);
endinterface

interface espm_result_if;
    import espm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SPEED_W-1:0]  speed_q16;
    logic signed [PERIOD_W-1:0] period_us;
    logic                       edge_accepted;

    modport source (output valid, speed_q16, period_us, edge_accepted, input ready);
    modport sink   (input valid, speed_q16, period_us, edge_accepted, output ready);
endinterface

interface espm_cfg_if;
    import espm_pkg::*;
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] index;
    logic [CFG_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/encoder_period_speed_meter.sv */
// Top level of the encoder period speed meter for one wheel channel.
// Each edge transaction carries a microsecond timestamp and the level of the second
// encoder line; the block answers with exactly one result: the signed speed in the
// selected unit (Q16), the current signed period and whether the edge passed the lockout.
// An edge passes from acceptance to a presented result through the lockout check and period
// update, the bit-serial divider (one quotient bit per cycle over the 41-bit numerator), the
// hand-over of the quotient and the load of the output register, which waits until the
// previous result is taken. One edge is in work at a time; the next edge is taken as soon
// as the current result sits in the output register, even while it waits to be taken.
// Configuration writes are always ready and belong in idle time.
`default_nettype none
module encoder_period_speed_meter #(
    parameter int TIME_WIDTH = espm_pkg::TIME_WIDTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    espm_edge_if.sink   edge_ch,
    espm_result_if.source result_ch,
    espm_cfg_if.sink    cfg_ch
);
    import espm_pkg::*;

    localparam int MAG_W = (TIME_WIDTH > PER_RST_W) ? TIME_WIDTH : PER_RST_W;
    localparam int EXT_W = (MAG_W > PERIOD_W) ? MAG_W : PERIOD_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    logic [UNIT_W-1:0] unit_mode_reg;
    logic [LOCK_W-1:0] lockout_us_reg;
    scale_t            degree_scale_reg;
    scale_t            radian_scale_reg;

    logic [TIME_WIDTH-1:0] last_edge_reg;
    logic [MAG_W-1:0]      period_mag_reg;
    logic                  period_neg_reg;

    logic [TIME_WIDTH-1:0] edge_time_reg;
    logic                  direction_reg;
    logic                  accepted_reg;

    logic                       out_valid_reg;
    logic signed [SPEED_W-1:0]  speed_reg;
    logic signed [PERIOD_W-1:0] period_out_reg;
    logic                       accepted_out_reg;

    logic [TIME_WIDTH-1:0] diff;
    logic                  pass;
    logic                  out_free;
    logic                  in_fire;
    scale_t                numerator;
    logic                  div_start;
    logic                  div_done;
    scale_t                quotient;
    logic [SPEED_W-1:0]    speed_mag;
    logic [EXT_W-1:0]      period_ext;
    logic [EXT_W-1:0]      period_signed;

    assign in_fire   = edge_ch.valid && edge_ch.ready;
    assign out_free  = !out_valid_reg || result_ch.ready;
    assign diff      = edge_time_reg - last_edge_reg;
    assign pass      = MAG_W'(diff) > MAG_W'(lockout_us_reg);
    assign div_start = (state_reg == ST_CHECK);

    always_comb
    begin
        case (unit_mode_reg)
            MODE_DEGREE: numerator = degree_scale_reg;
            MODE_RADIAN: numerator = radian_scale_reg;
            default:     numerator = '0;
        endcase
    end

    // divisor taken from the period as it stands after this edge's update
    espm_div #(
        .NUM_W (SCALE_W),
        .DEN_W (MAG_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .numerator (numerator),
        .divisor   (pass ? MAG_W'(diff) : period_mag_reg),
        .done      (div_done),
        .quotient  (quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_fire) state_next = ST_CHECK;
            ST_CHECK: state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_HOLD;
            ST_HOLD:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign edge_ch.ready = (state_reg == ST_IDLE);
    assign cfg_ch.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_mode_reg    <= MODE_DEGREE;
            lockout_us_reg   <= LOCKOUT_RESET;
            degree_scale_reg <= DEGREE_RESET;
            radian_scale_reg <= RADIAN_RESET;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                REG_UNIT_MODE:    unit_mode_reg    <= cfg_ch.data[UNIT_W-1:0];
                REG_LOCKOUT_US:   lockout_us_reg   <= cfg_ch.data[LOCK_W-1:0];
                REG_DEGREE_SCALE: degree_scale_reg <= cfg_ch.data[SCALE_W-1:0];
                REG_RADIAN_SCALE: radian_scale_reg <= cfg_ch.data[SCALE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_edge_reg  <= '0;
            period_mag_reg <= MAG_W'(PERIOD_RESET);
            period_neg_reg <= 1'b0;
        end
        else if (state_reg == ST_CHECK && pass)
        begin
            last_edge_reg  <= edge_time_reg;
            period_mag_reg <= MAG_W'(diff);
            period_neg_reg <= !direction_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            edge_time_reg <= edge_ch.edge_time_us;
            direction_reg <= edge_ch.direction_level;
        end
        if (state_reg == ST_CHECK)
            accepted_reg <= pass;
    end

    assign speed_mag     = SPEED_W'(quotient);
    assign period_ext    = EXT_W'(period_mag_reg);
    assign period_signed = period_neg_reg ? (~period_ext + 1'b1) : period_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_HOLD && out_free)
            out_valid_reg <= 1'b1;
        else if (result_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_HOLD && out_free)
        begin
            speed_reg        <= period_neg_reg ? (~speed_mag + 1'b1) : speed_mag;
            period_out_reg   <= period_signed[PERIOD_W-1:0];
            accepted_out_reg <= accepted_reg;
        end
    end

    assign result_ch.valid         = out_valid_reg;
    assign result_ch.speed_q16     = speed_reg;
    assign result_ch.period_us     = period_out_reg;
    assign result_ch.edge_accepted = accepted_out_reg;

    a_accept_starts_check: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == ST_CHECK)
        else $error("accepted edge did not enter the lockout check");

    a_done_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_result_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(state_reg) == ST_HOLD)
        else $error("result appeared without a finished division");

    a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        period_mag_reg != '0)
        else $error("stored period became zero");

endmodule
`default_nettype wire

/* rtl/espm_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle, zero divisor gives zero.
`default_nettype none
module espm_div #(
    parameter int NUM_W = espm_pkg::SCALE_W,
    parameter int DEN_W = espm_pkg::TIME_WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] numerator,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  done,
    output logic [NUM_W-1:0]      quotient
);
    import espm_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] count_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic             zero_reg;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] num_next;

    always_comb
    begin
        shifted  = {rem_reg, num_reg[NUM_W-1]};
        trial    = shifted - {1'b0, den_reg};
        fits     = shifted >= {1'b0, den_reg};
        rem_next = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
        num_next = {num_reg[NUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= numerator;
            den_reg  <= divisor;
            rem_reg  <= '0;
            zero_reg <= (divisor == '0);
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = zero_reg ? '0 : num_reg;

endmodule
`default_nettype wire
